// ----- src/leftmost_below_stamp_tree_top_defines.svh -----
// assertion macros used by the tree top rtl file
`ifndef LEFTMOST_BELOW_STAMP_TREE_TOP_DEFINES_SVH
`define LEFTMOST_BELOW_STAMP_TREE_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define LBST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define LBST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/lbst_pkg.sv -----
`default_nettype none
package lbst_pkg;

	localparam int STAMP_W = 16;
	localparam int IDX_W   = 10;

	localparam logic CMD_MARK = 1'b0;
	localparam logic CMD_FIND = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MARK,
		ST_FIND
	} state_t;

endpackage
`default_nettype wire

// ----- src/lbst_ram.sv -----
`default_nettype none
module lbst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ----- src/leftmost_below_stamp_tree_top.sv -----
`default_nettype none
// min tree over LEAVES leaf stamps, kept in one ram of 2*LEAVES entries
// (entry 1 is the root, children of n are 2n and 2n+1, leaves start at LEAVES)
// command channel: an item is taken at a clock edge with start high and busy low
//   cmd = mark: stamp is written to leaf leaf_index (wrapped to the leaf count),
//     then every ancestor is recomputed; no result. busy after the accepting edge
//     until the root is written, one tree level per cycle
//   cmd = find: walk down from the root, left while the left child min is below
//     stamp; found_valid pulses for one cycle with found_index (last leaf if
//     nothing is below). busy until the walk reaches a leaf; the strobe comes in the
//     cycle after the last level, while the next item may already be taken
// each level costs one registered ram read; a mark also writes the
// parent in that same cycle through the separate write port
// results cannot be held off: found_valid is a single-cycle strobe
// reset: the ram is swept to zero, one entry per cycle, with busy high; no item
// is taken until the sweep is done
module leftmost_below_stamp_tree_top #(
	parameter int LEAVES = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            cmd,
	input  wire logic [lbst_pkg::IDX_W-1:0]      leaf_index,
	input  wire logic [lbst_pkg::STAMP_W-1:0]    stamp,
	output logic                                 found_valid,
	output logic      [lbst_pkg::IDX_W-1:0]      found_index
);

`include "leftmost_below_stamp_tree_top_defines.svh"

	localparam int LVL_W  = $clog2(LEAVES);
	localparam int NODE_W = LVL_W + 1;
	localparam int DEPTH  = 2 * LEAVES;

	localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(DEPTH - 1);
	localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
	localparam logic [NODE_W-1:0] ROOT_LEFT = NODE_W'(2);

	lbst_pkg::state_t state_q, state_d;

	// walk registers
	logic [NODE_W-1:0]            node_q;   // mark: current node, find: left child being read
	logic [lbst_pkg::STAMP_W-1:0] cur_q;    // mark: min carried up the path
	logic [lbst_pkg::STAMP_W-1:0] thr_q;    // find: threshold
	logic [NODE_W-1:0]            clr_q;    // clear sweep address

	logic                         found_valid_q;
	logic [lbst_pkg::IDX_W-1:0]   found_index_q;

	// ram port signals
	logic                         wr_en;
	logic [NODE_W-1:0]            wr_addr;
	logic [lbst_pkg::STAMP_W-1:0] wr_data;
	logic [NODE_W-1:0]            rd_addr;
	logic [lbst_pkg::STAMP_W-1:0] rd_data;

	logic                         accept;
	logic [LVL_W+lbst_pkg::IDX_W-1:0] leaf_wide;
	logic [NODE_W-1:0]            leaf_node;
	logic [NODE_W-1:0]            parent;
	logic [lbst_pkg::STAMP_W-1:0] up_min;
	logic [NODE_W-1:0]            child;
	logic [NODE_W-1:0]            next_left;
	logic [LVL_W+lbst_pkg::IDX_W-1:0] found_wide;
	logic                         find_done;

	assign busy   = (state_q != lbst_pkg::ST_IDLE);
	assign accept = start && !busy;

	// leaf index wraps to the leaf count, leaves sit in the upper half
	assign leaf_wide = {{LVL_W{1'b0}}, leaf_index};
	assign leaf_node = {1'b1, leaf_wide[LVL_W-1:0]};

	// mark step: combine carried value with the sibling just read
	assign parent = {1'b0, node_q[NODE_W-1:1]};
	assign up_min = (rd_data < cur_q) ? rd_data : cur_q;

	// find step: go left if the left child min is below the threshold
	assign child      = {node_q[NODE_W-1:1], ~(rd_data < thr_q)};
	assign next_left  = {child[NODE_W-2:0], 1'b0};
	assign found_wide = {{lbst_pkg::IDX_W{1'b0}}, child[LVL_W-1:0]};

	lbst_ram #(
		.WIDTH (lbst_pkg::STAMP_W),
		.DEPTH (DEPTH)
	) u_tree_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lbst_pkg::ST_CLEAR: begin
				if (clr_q == LAST_NODE) begin
					state_d = lbst_pkg::ST_IDLE;
				end
			end
			lbst_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (cmd == lbst_pkg::CMD_MARK) ? lbst_pkg::ST_MARK
						: lbst_pkg::ST_FIND;
				end
			end
			lbst_pkg::ST_MARK: begin
				if (parent == ROOT_NODE) begin
					state_d = lbst_pkg::ST_IDLE;
				end
			end
			lbst_pkg::ST_FIND: begin
				if (child[NODE_W-1]) begin
					state_d = lbst_pkg::ST_IDLE;
				end
			end
			default: state_d = lbst_pkg::ST_IDLE;
		endcase
	end

	// ram control and find completion
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = '0;
		rd_addr   = '0;
		find_done = 1'b0;
		unique case (state_q)
			lbst_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			lbst_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd == lbst_pkg::CMD_MARK) begin
						// write the leaf, fetch its sibling
						wr_en   = 1'b1;
						wr_addr = leaf_node;
						wr_data = stamp;
						rd_addr = {leaf_node[NODE_W-1:1], ~leaf_node[0]};
					end else begin
						rd_addr = ROOT_LEFT;
					end
				end
			end
			lbst_pkg::ST_MARK: begin
				// parent gets the new min, its sibling is fetched for the next level
				wr_en   = 1'b1;
				wr_addr = parent;
				wr_data = up_min;
				rd_addr = {parent[NODE_W-1:1], ~parent[0]};
			end
			lbst_pkg::ST_FIND: begin
				rd_addr   = next_left;
				find_done = child[NODE_W-1];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lbst_pkg::ST_CLEAR;
			clr_q         <= '0;
			found_valid_q <= 1'b0;
			found_index_q <= '0;
		end else begin
			state_q       <= state_d;
			found_valid_q <= find_done;
			if (state_q == lbst_pkg::ST_CLEAR) begin
				clr_q <= clr_q + NODE_W'(1);
			end
			if (find_done) begin
				found_index_q <= found_wide[lbst_pkg::IDX_W-1:0];
			end
		end
	end

	// walk datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			lbst_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd == lbst_pkg::CMD_MARK) begin
						node_q <= leaf_node;
						cur_q  <= stamp;
					end else begin
						node_q <= ROOT_LEFT;
						thr_q  <= stamp;
					end
				end
			end
			lbst_pkg::ST_MARK: begin
				node_q <= parent;
				cur_q  <= up_min;
			end
			lbst_pkg::ST_FIND: begin
				node_q <= next_left;
			end
			default: begin
				node_q <= node_q;
			end
		endcase
	end

	assign found_valid = found_valid_q;
	assign found_index = found_index_q;

	`LBST_ASSERT_IMP(a_clear_blocks_items, state_q == lbst_pkg::ST_CLEAR, busy, "item taken during clear sweep")
	`LBST_ASSERT_IMP(a_strobe_after_find, found_valid_q, $past(state_q) == lbst_pkg::ST_FIND, "result strobe without a find walk")
	`LBST_ASSERT_IMP(a_mark_writes_inner, state_q == lbst_pkg::ST_MARK, wr_en && !wr_addr[NODE_W-1] && (wr_addr != '0), "mark wrote outside the inner nodes")
	`LBST_ASSERT_NXT(a_mark_ends_at_root, state_q == lbst_pkg::ST_MARK && parent == ROOT_NODE, state_q == lbst_pkg::ST_IDLE, "mark did not finish after the root")

endmodule
`default_nettype wire

// ----- sim/leftmost_below_stamp_tree_top_tb.sv -----
`timescale 1ns / 1ps

module leftmost_below_stamp_tree_top_tb;

	localparam int LEAVES     = 1024;
	localparam int IDX_W      = lbst_pkg::IDX_W;
	localparam int STAMP_W    = lbst_pkg::STAMP_W;
	localparam int STALL_MAX  = 20000;	// idle cycles before the run is called hung
	localparam int DRAIN_WAIT = 40;		// cycles watched after the last result

	typedef struct {
		logic               op;
		logic [IDX_W-1:0]   idx;
		logic [STAMP_W-1:0] st;
	} tree_item_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #2 clk = ~clk;

	// block inputs start at known values
	logic               start      = 1'b0;
	logic               cmd        = lbst_pkg::CMD_MARK;
	logic [IDX_W-1:0]   leaf_index = '0;
	logic [STAMP_W-1:0] stamp      = '0;
	logic               busy;
	logic               found_valid;
	logic [IDX_W-1:0]   found_index;

	leftmost_below_stamp_tree_top #(
		.LEAVES(LEAVES)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.leaf_index (leaf_index),
		.stamp      (stamp),
		.found_valid(found_valid),
		.found_index(found_index)
	);

	tree_item_t         pending_items[$];	// items not yet offered to the block
	logic [IDX_W-1:0]   expected_found[$];	// leaf index owed for each accepted find
	logic [STAMP_W-1:0] min_copy[2*LEAVES];	// our own min tree, root at entry 1
	logic [STAMP_W-1:0] leaf_stamps[LEAVES];	// leaf values as the stimulus has set them
	int                 fail_count = 0;
	int                 quiet_cycles = 0;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// write a leaf, then refresh the minimum of every ancestor up to the root
	function automatic void tree_store(logic [IDX_W-1:0] idx, logic [STAMP_W-1:0] st);
		int unsigned node;
		node = (int'(idx) & (LEAVES - 1)) + LEAVES;
		min_copy[node] = st;
		for (node = node >> 1; node != 0; node = node >> 1)
			min_copy[node] = (min_copy[2*node] > min_copy[2*node+1]) ?
				min_copy[2*node+1] : min_copy[2*node];
	endfunction

	// walk down, left whenever the left subtree holds a stamp below the threshold
	function automatic logic [IDX_W-1:0] leftmost_below(logic [STAMP_W-1:0] thr);
		int unsigned node;
		node = 1;
		while (node < LEAVES)
			node = (min_copy[2*node] < thr) ? 2*node : 2*node + 1;
		return IDX_W'(node - LEAVES);
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic void push_mark(logic [IDX_W-1:0] idx, logic [STAMP_W-1:0] st);
		tree_item_t it;
		it.op  = lbst_pkg::CMD_MARK;
		it.idx = idx;
		it.st  = st;
		leaf_stamps[int'(idx) & (LEAVES - 1)] = st;
		pending_items.push_back(it);
	endfunction

	// leaf_index is don't-care on a find, so it gets noise
	function automatic void push_find(logic [STAMP_W-1:0] thr);
		tree_item_t it;
		it.op  = lbst_pkg::CMD_FIND;
		it.idx = IDX_W'($urandom);
		it.st  = thr;
		pending_items.push_back(it);
	endfunction

	// thresholds cluster just above the lowest stamp so the walk goes deep
	function automatic logic [STAMP_W-1:0] pick_threshold();
		int lowest;
		int r;
		lowest = 65535;
		foreach (leaf_stamps[i])
			if (int'(leaf_stamps[i]) < lowest)
				lowest = int'(leaf_stamps[i]);
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		else if (r < 10)
			return '1;
		else if (r < 20)
			return STAMP_W'(lowest);	// nothing strictly below, last leaf expected
		else if (r < 70)
			return STAMP_W'((lowest + $urandom_range(1, 64) > 65535) ?
				65535 : lowest + $urandom_range(1, 64));
		else if (r < 90)
			return STAMP_W'((lowest + $urandom_range(1, 4096) > 65535) ?
				65535 : lowest + $urandom_range(1, 4096));
		else
			return STAMP_W'($urandom);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// driver: offers queued items, predicts on each accepted one
	// ------------------------------------------------------------------

	int idle_left   = 0;	// low cycles still owed before the next item
	int steady_left = 0;	// items still to send back to back

	always @(posedge clk or negedge arst_n) begin
		tree_item_t it;
		logic       taken;
		if (!arst_n) begin
			start       <= 1'b0;
			idle_left   <= 0;
			steady_left <= 0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				if (cmd == lbst_pkg::CMD_MARK)
					tree_store(leaf_index, stamp);
				else
					expected_found.push_back(leftmost_below(stamp));
			end
			// start may only move once the current item is gone
			if (taken || !start) begin
				if (idle_left != 0) begin
					start     <= 1'b0;
					idle_left <= idle_left - 1;
				end else if (pending_items.size() != 0) begin
					it = pending_items.pop_front();
					start      <= 1'b1;
					cmd        <= it.op;
					leaf_index <= it.idx;
					stamp      <= it.st;
					if (steady_left != 0) begin
						steady_left <= steady_left - 1;
					end else begin
						idle_left <= draw_gap();
						if ($urandom_range(0, 49) == 0)
							steady_left <= $urandom_range(10, 40);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: every strobe must match the oldest outstanding find
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		logic [IDX_W-1:0] want;
		if (arst_n && found_valid) begin
			if (expected_found.size() == 0) begin
				$display("%0t: found_index %0d with no find outstanding", $time, found_index);
				fail_count <= fail_count + 1;
			end else begin
				want = expected_found.pop_front();
				if (found_index !== want) begin
					$display("%0t: found_index mismatch, expected %0d, got %0d",
						$time, want, found_index);
					fail_count <= fail_count + 1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: counts cycles in which neither an item nor a result moves
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || found_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_MAX) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_MAX);
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------

	initial begin
		int r;
		int n;
		foreach (min_copy[i])
			min_copy[i] = '0;
		foreach (leaf_stamps[i])
			leaf_stamps[i] = '0;

		// directed: fresh tree is all zero
		push_find(16'h0000);			// threshold zero, last leaf
		push_find(16'h0001);			// every leaf below, leaf 0
		push_find(16'hFFFF);
		push_mark(10'd0, 16'hFFFF);
		push_find(16'hFFFF);			// leaf 0 no longer below, leaf 1
		push_mark(10'd1, 16'hFFFF);
		push_mark(10'h3FF, 16'h0000);
		push_mark(10'h2AA, 16'h5555);
		push_mark(10'h155, 16'hAAAA);
		push_find(16'h0001);
		push_find(16'h5556);
		push_find(16'h5555);			// equal is not below
		push_find(16'hAAAB);
		push_find(16'h0000);
		for (int i = 2; i < 8; i++)
			push_mark(IDX_W'(i), 16'hFFFF);
		push_find(16'hFFFF);			// first untouched leaf
		push_mark(10'd0, 16'h0000);		// low value back at the far left
		push_find(16'h0001);
		push_find(16'hFFFF);

		// sweep every leaf with a high stamp, finds mixed in; untouched leaves
		// are still zero, so the answer follows the sweep front
		for (int i = 0; i < LEAVES; i++) begin
			r = $urandom_range(0, 99);
			push_mark(IDX_W'(i),
				(r < 5) ? 16'hFFFF : STAMP_W'($urandom_range(16'h0100, 16'hFFFF)));
			if ($urandom_range(0, 5) == 0)
				push_find(pick_threshold());
		end

		// mixed updates and lookups on the filled tree
		for (n = 0; n < 220; n++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				push_find(pick_threshold());
			end else if (r < 60) begin
				// lift the current minimum so the answer moves elsewhere
				int lo_idx;
				lo_idx = 0;
				foreach (leaf_stamps[i])
					if (leaf_stamps[i] < leaf_stamps[lo_idx])
						lo_idx = i;
				push_mark(IDX_W'(lo_idx), STAMP_W'($urandom_range(16'h8000, 16'hFFFF)));
			end else if (r < 63) begin
				push_mark(IDX_W'($urandom), 16'h0000);
			end else if (r < 68) begin
				push_mark(IDX_W'($urandom), STAMP_W'($urandom_range(1, 255)));
			end else if (r < 75) begin
				push_mark(IDX_W'($urandom), 16'hFFFF);
			end else begin
				push_mark(IDX_W'($urandom), STAMP_W'($urandom_range(16'h0100, 16'hFFFF)));
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// drain: everything offered, taken and answered
		while (pending_items.size() != 0 || start || expected_found.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/lbst_pkg.sv
src/lbst_ram.sv
src/leftmost_below_stamp_tree_top.sv
sim/leftmost_below_stamp_tree_top_tb.sv
